@@ sv/lsb_pixel_stego_embed_extract_core_defines.svh @@
// Assertion macros used by the checked RTL core.
`ifndef LSB_PIXEL_STEGO_EMBED_EXTRACT_CORE_DEFINES_SVH
`define LSB_PIXEL_STEGO_EMBED_EXTRACT_CORE_DEFINES_SVH

// Same-cycle implication, off while in reset.
`define LPSE_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("lpse check failed");

// Next-cycle implication, off while in reset.
`define LPSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("lpse check failed");

`endif

@@ sv/lpse_pkg.sv @@
package lpse_pkg;

   localparam int HEADER_BITS = 64;
   localparam int HP_W        = $clog2(HEADER_BITS + 1);
   localparam int HIDX_W      = (HEADER_BITS > 1) ? $clog2(HEADER_BITS) : 1;
   localparam int LEN_W       = 32;
   localparam int CNT_W       = 32;
   localparam int DLEN_W      = HEADER_BITS;
   localparam int CMP_W       = (DLEN_W > CNT_W) ? DLEN_W : CNT_W;
   localparam int PIX_W       = 8;
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 32;

   localparam logic [CNT_W-1:0] CNT_MAX = {CNT_W{1'b1}};

   localparam logic MODE_EMBED   = 1'b0;
   localparam logic MODE_EXTRACT = 1'b1;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MODE           = 1'b0,
      CSR_MESSAGE_LENGTH = 1'b1
   } lpse_csr_type;

   typedef struct packed {
      logic [HP_W-1:0]   hdr_pos;
      logic [2:0]        bit_pos;
      logic [7:0]        held_byte;
      logic [7:0]        asm_byte;
      logic [DLEN_W-1:0] dec_len;
      logic [CNT_W-1:0]  byte_cnt;
   } lpse_state_type;

   typedef struct packed {
      logic [PIX_W-1:0] blue_out;
      logic             byte_valid;
      logic [7:0]       byte_out;
      logic             last_byte;
   } lpse_result_type;

endpackage

@@ sv/lpse_req_if.sv @@
interface lpse_req_if;
   logic                        valid;
   logic                        ready;
   logic                        first_pixel;
   logic [lpse_pkg::PIX_W-1:0]  blue_in;
   logic [7:0]                  message_byte;

   modport source (output valid, output first_pixel, output blue_in, output message_byte,
                   input ready);
   modport sink   (input valid, input first_pixel, input blue_in, input message_byte,
                   output ready);
endinterface

@@ sv/lpse_rsp_if.sv @@
interface lpse_rsp_if;
   logic                        valid;
   logic                        ready;
   logic [lpse_pkg::PIX_W-1:0]  blue_out;
   logic                        byte_valid;
   logic [7:0]                  byte_out;
   logic                        last_byte;

   modport source (output valid, output blue_out, output byte_valid, output byte_out,
                   output last_byte, input ready);
   modport sink   (input valid, input blue_out, input byte_valid, input byte_out,
                   input last_byte, output ready);
endinterface

@@ sv/lpse_step.sv @@
module lpse_step (
   input  lpse_pkg::lpse_state_type       state_cur,
   input  logic                           mode,
   input  logic [lpse_pkg::LEN_W-1:0]     message_length,
   input  logic                           first_pixel,
   input  logic [lpse_pkg::PIX_W-1:0]     blue_in,
   input  logic [7:0]                     message_byte,
   output lpse_pkg::lpse_state_type       state_nxt,
   output lpse_pkg::lpse_result_type      result
);

   logic [lpse_pkg::CMP_W-1:0]       len_ext;
   logic [lpse_pkg::HEADER_BITS-1:0] hdr_word;

   assign len_ext  = lpse_pkg::CMP_W'(message_length);
   assign hdr_word = len_ext[lpse_pkg::HEADER_BITS-1:0];

   always_comb begin
      lpse_pkg::lpse_state_type     st;
      logic [lpse_pkg::HP_W-1:0]    hdr_idx;
      logic                         hdr_bit;
      logic                         lsb;
      logic [7:0]                   cur_byte;
      logic [2:0]                   bit_nxt;
      logic                         was_max;
      logic [lpse_pkg::CNT_W-1:0]   cnt_inc;

      st = state_cur;
      if (first_pixel) begin
         st.hdr_pos  = '0;
         st.bit_pos  = '0;
         st.byte_cnt = '0;
         st.dec_len  = '0;
         st.asm_byte = '0;
      end

      hdr_idx  = lpse_pkg::HP_W'(lpse_pkg::HEADER_BITS - 1) - st.hdr_pos;
      hdr_bit  = hdr_word[hdr_idx[lpse_pkg::HIDX_W-1:0]];
      lsb      = blue_in[0];
      cur_byte = (st.bit_pos == 3'd0) ? message_byte : st.held_byte;
      bit_nxt  = st.bit_pos + 3'd1;
      was_max  = (st.byte_cnt == lpse_pkg::CNT_MAX);
      cnt_inc  = was_max ? st.byte_cnt : st.byte_cnt + lpse_pkg::CNT_W'(1);

      result = '{blue_out: blue_in, byte_valid: 1'b0, byte_out: 8'd0, last_byte: 1'b0};

      if (mode == lpse_pkg::MODE_EMBED) begin
         if (st.hdr_pos < lpse_pkg::HP_W'(lpse_pkg::HEADER_BITS)) begin
            result.blue_out = {blue_in[lpse_pkg::PIX_W-1:1], hdr_bit};
            st.hdr_pos      = st.hdr_pos + lpse_pkg::HP_W'(1);
         end else if (st.byte_cnt < message_length) begin
            st.held_byte    = cur_byte;
            result.blue_out = {blue_in[lpse_pkg::PIX_W-1:1], cur_byte[3'd7 - st.bit_pos]};
            st.bit_pos      = bit_nxt;
            if (bit_nxt == 3'd0) begin
               st.byte_cnt = cnt_inc;
            end
         end
      end else begin
         if (st.hdr_pos < lpse_pkg::HP_W'(lpse_pkg::HEADER_BITS)) begin
            // shift the length header in from the low end
            st.dec_len = (st.dec_len << 1) | lpse_pkg::DLEN_W'(lsb);
            st.hdr_pos = st.hdr_pos + lpse_pkg::HP_W'(1);
         end else if (lpse_pkg::CMP_W'(st.byte_cnt) < lpse_pkg::CMP_W'(st.dec_len)) begin
            st.asm_byte = {st.asm_byte[6:0], lsb};
            st.bit_pos  = bit_nxt;
            if (bit_nxt == 3'd0) begin
               st.byte_cnt       = cnt_inc;
               result.byte_valid = 1'b1;
               result.byte_out   = st.asm_byte;
               result.last_byte  = !was_max &&
                  (lpse_pkg::CMP_W'(cnt_inc) == lpse_pkg::CMP_W'(st.dec_len));
            end
         end
      end

      state_nxt = st;
   end

endmodule

@@ sv/lsb_pixel_stego_embed_extract_core.sv @@
// Pixel LSB message embed/extract core. One blue byte per beat on req_ch, one result beat
// per pixel on rsp_ch, in the next cycle through an output register; a pixel is taken every
// clock while rsp_ch is ready or the output register is empty. Embed (mode 0) writes
// message_length, MSB first, into the LSBs of the first header pixels, then the message
// bytes MSB first, message_byte being sampled on the first pixel of each byte. Extract
// (mode 1) reads the length back and emits each byte on byte_valid, flagging the final one
// with last_byte. first_pixel restarts the counters.
// Write the CSRs only while no beat is in flight.
`include "lsb_pixel_stego_embed_extract_core_defines.svh"

module lsb_pixel_stego_embed_extract_core (
   input  logic                              clock,
   input  logic                              reset,
   lpse_req_if.sink                          req_ch,
   lpse_rsp_if.source                        rsp_ch,
   input  logic                              csr_we,
   input  logic [lpse_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [lpse_pkg::CSR_DATA_W-1:0]   csr_wdata
);

   logic                             mode_ff;
   logic [lpse_pkg::LEN_W-1:0]       msg_len_ff;
   lpse_pkg::lpse_state_type         state_ff;
   lpse_pkg::lpse_state_type         state_in;
   lpse_pkg::lpse_result_type        result_ff;
   lpse_pkg::lpse_result_type        result_in;
   logic                             rsp_valid_ff;
   logic                             accept;

   assign req_ch.ready = !rsp_valid_ff || rsp_ch.ready;
   assign accept       = req_ch.valid && req_ch.ready;

   lpse_step u_step (
      .state_cur      (state_ff),
      .mode           (mode_ff),
      .message_length (msg_len_ff),
      .first_pixel    (req_ch.first_pixel),
      .blue_in        (req_ch.blue_in),
      .message_byte   (req_ch.message_byte),
      .state_nxt      (state_in),
      .result         (result_in)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff    <= lpse_pkg::MODE_EMBED;
         msg_len_ff <= '0;
      end else if (csr_we) begin
         case (lpse_pkg::lpse_csr_type'(csr_index))
            lpse_pkg::CSR_MODE:           mode_ff    <= csr_wdata[0];
            lpse_pkg::CSR_MESSAGE_LENGTH: msg_len_ff <= csr_wdata[lpse_pkg::LEN_W-1:0];
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (accept) begin
            state_ff <= state_in;
         end
         // hold the result until taken, refill on a new beat
         if (accept) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ch.ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         result_ff <= result_in;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.blue_out   = result_ff.blue_out;
   assign rsp_ch.byte_valid = result_ff.byte_valid;
   assign rsp_ch.byte_out   = result_ff.byte_out;
   assign rsp_ch.last_byte  = result_ff.last_byte;

   `LPSE_ASSERT_NEXT(a_accept_loads_rsp, clock, reset, accept, rsp_valid_ff)
   `LPSE_ASSERT_NEXT(a_state_holds_idle, clock, reset, !accept, $stable(state_ff))
   `LPSE_ASSERT_NOW(a_hdr_pos_bound, clock, reset, 1'b1,
      state_ff.hdr_pos <= lpse_pkg::HP_W'(lpse_pkg::HEADER_BITS))
   `LPSE_ASSERT_NOW(a_last_needs_byte, clock, reset, rsp_valid_ff && result_ff.last_byte,
      result_ff.byte_valid)

endmodule

@@ sim/lsb_pixel_stego_embed_extract_core_tb.sv @@
`timescale 1ns / 100ps

module lsb_pixel_stego_embed_extract_core_tb;

   // Shadow copy of the embed/extract datapath plus the queue of predicted result beats.
   class stego_shadow;
      logic                          mode;
      logic [lpse_pkg::LEN_W-1:0]    msg_len;
      logic [lpse_pkg::HP_W-1:0]     hdr_pos;
      logic [2:0]                    bit_pos;
      logic [7:0]                    held_byte;
      logic [7:0]                    asm_byte;
      logic [lpse_pkg::DLEN_W-1:0]   dec_len;
      logic [lpse_pkg::CNT_W-1:0]    byte_cnt;
      lpse_pkg::lpse_result_type     pending_beats[$];
      int                            mismatches;

      function new();
         mode       = lpse_pkg::MODE_EMBED;
         msg_len    = '0;
         hdr_pos    = '0;
         bit_pos    = '0;
         held_byte  = '0;
         asm_byte   = '0;
         dec_len    = '0;
         byte_cnt   = '0;
         mismatches = 0;
      endfunction

      function void set_reg(lpse_pkg::lpse_csr_type idx,
                            logic [lpse_pkg::CSR_DATA_W-1:0] value);
         case (idx)
            lpse_pkg::CSR_MODE:           mode = value[0];
            lpse_pkg::CSR_MESSAGE_LENGTH: msg_len = value[lpse_pkg::LEN_W-1:0];
            default: ;
         endcase
      endfunction

      function void bump_count();
         if (byte_cnt != lpse_pkg::CNT_MAX)
            byte_cnt = byte_cnt + 1'b1;
      endfunction

      function void note_pixel(logic first, logic [lpse_pkg::PIX_W-1:0] blue, logic [7:0] msg);
         lpse_pkg::lpse_result_type beat;
         logic [63:0]               len64;
         int                        sh;
         logic                      was_max;
         beat.blue_out   = blue;
         beat.byte_valid = 1'b0;
         beat.byte_out   = '0;
         beat.last_byte  = 1'b0;
         if (first) begin
            hdr_pos  = '0;
            bit_pos  = '0;
            byte_cnt = '0;
            dec_len  = '0;
            asm_byte = '0;
         end
         if (mode == lpse_pkg::MODE_EMBED) begin
            if (int'(hdr_pos) < lpse_pkg::HEADER_BITS) begin
               len64 = 64'(msg_len);
               sh = (lpse_pkg::HEADER_BITS - 1 - int'(hdr_pos)) & 63;
               beat.blue_out = {blue[lpse_pkg::PIX_W-1:1], len64[sh]};
               hdr_pos = hdr_pos + 1'b1;
            end else if (byte_cnt < msg_len) begin
               if (bit_pos == 3'd0)
                  held_byte = msg;
               beat.blue_out = {blue[lpse_pkg::PIX_W-1:1], held_byte[3'd7 - bit_pos]};
               bit_pos = bit_pos + 1'b1;
               if (bit_pos == 3'd0)
                  bump_count();
            end
         end else begin
            if (int'(hdr_pos) < lpse_pkg::HEADER_BITS) begin
               dec_len = (dec_len << 1) | lpse_pkg::DLEN_W'(blue[0]);
               hdr_pos = hdr_pos + 1'b1;
            end else if (lpse_pkg::CMP_W'(byte_cnt) < lpse_pkg::CMP_W'(dec_len)) begin
               asm_byte = {asm_byte[6:0], blue[0]};
               bit_pos = bit_pos + 1'b1;
               if (bit_pos == 3'd0) begin
                  was_max = (byte_cnt == lpse_pkg::CNT_MAX);
                  bump_count();
                  beat.byte_valid = 1'b1;
                  beat.byte_out   = asm_byte;
                  beat.last_byte  = !was_max &&
                     (lpse_pkg::CMP_W'(byte_cnt) == lpse_pkg::CMP_W'(dec_len));
               end
            end
         end
         pending_beats.push_back(beat);
      endfunction

      function void check_field(string name, logic [7:0] want, logic [7:0] got);
         if (got !== want) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            mismatches++;
         end
      endfunction

      function void check_beat(lpse_pkg::lpse_result_type got);
         lpse_pkg::lpse_result_type want;
         if (pending_beats.size() == 0) begin
            $display("%0t: unexpected beat, expected none, actual %0h", $time, got);
            mismatches++;
            return;
         end
         want = pending_beats.pop_front();
         check_field("blue_out", want.blue_out, got.blue_out);
         check_field("byte_valid", 8'(want.byte_valid), 8'(got.byte_valid));
         check_field("byte_out", want.byte_out, got.byte_out);
         check_field("last_byte", 8'(want.last_byte), 8'(got.last_byte));
      endfunction
   endclass

   logic                              clock;
   logic                              reset;
   logic                              csr_we;
   logic [lpse_pkg::CSR_IDX_W-1:0]    csr_index;
   logic [lpse_pkg::CSR_DATA_W-1:0]   csr_wdata;

   lpse_req_if req_ch();
   lpse_rsp_if rsp_ch();

   stego_shadow shadow = new();
   int pixels_sent = 0;
   int tx_idle_pct = 21;
   int rx_idle_pct = 52;

   lsb_pixel_stego_embed_extract_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_ch    (req_ch),
      .rsp_ch    (rsp_ch),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #2_000_000;
      $display("lsb_pixel_stego_embed_extract_core test failed");
      $finish;
   end

   // Watch both channels at every edge and steer the idle mix by progress.
   always @(posedge clock) begin : monitor_blk
      lpse_pkg::lpse_result_type got;
      if (!reset) begin
         if (req_ch.valid && req_ch.ready) begin
            shadow.note_pixel(req_ch.first_pixel, req_ch.blue_in, req_ch.message_byte);
            pixels_sent++;
         end
         if (rsp_ch.valid && rsp_ch.ready) begin
            got.blue_out   = rsp_ch.blue_out;
            got.byte_valid = rsp_ch.byte_valid;
            got.byte_out   = rsp_ch.byte_out;
            got.last_byte  = rsp_ch.last_byte;
            shadow.check_beat(got);
         end
      end
      if (pixels_sent < 567) begin
         tx_idle_pct = 21;
         rx_idle_pct = 52;
      end else if (pixels_sent < 1134) begin
         tx_idle_pct = 52;
         rx_idle_pct = 21;
      end else begin
         tx_idle_pct = 0;
         rx_idle_pct = 0;
      end
      rsp_ch.ready <= ($urandom_range(99, 0) >= rx_idle_pct);
   end

   task automatic send_pixel(input logic first, input logic [lpse_pkg::PIX_W-1:0] blue,
                             input logic [7:0] msg);
      while ($urandom_range(99, 0) < tx_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid        <= 1'b1;
      req_ch.first_pixel  <= first;
      req_ch.blue_in      <= blue;
      req_ch.message_byte <= msg;
      do @(posedge clock); while (!req_ch.ready);
   endtask

   // Hold off the sender until every predicted beat has come back.
   task automatic wait_drained();
      req_ch.valid <= 1'b0;
      do @(posedge clock); while (shadow.pending_beats.size() != 0);
      repeat (2) @(posedge clock);
   endtask

   task automatic write_reg(input lpse_pkg::lpse_csr_type idx,
                            input logic [lpse_pkg::CSR_DATA_W-1:0] value);
      csr_we    <= 1'b1;
      csr_index <= idx;
      csr_wdata <= value;
      @(posedge clock);
      csr_we <= 1'b0;
      shadow.set_reg(idx, value);
      @(posedge clock);
   endtask

   // One image: header pixels carry hdr in their LSBs when plant is set.
   task automatic run_image(input int n_pix, input logic [63:0] hdr, input logic plant,
                            input logic restart, input int pause_at, input logic flip);
      logic [lpse_pkg::PIX_W-1:0] blue;
      logic                       nm;
      for (int i = 0; i < n_pix; i++) begin
         blue = lpse_pkg::PIX_W'($urandom);
         if (plant && i < lpse_pkg::HEADER_BITS)
            blue[0] = hdr[lpse_pkg::HEADER_BITS - 1 - i];
         if (i == pause_at) begin
            wait_drained();
            if (flip) begin
               nm = ~shadow.mode;
               write_reg(lpse_pkg::CSR_MODE, {31'b0, nm});
            end
         end
         send_pixel(restart && (i == 0), blue, 8'($urandom));
      end
   endtask

   initial begin : stimulus_blk
      logic [63:0]                     hdr;
      logic [lpse_pkg::CSR_DATA_W-1:0] len;
      logic [lpse_pkg::CSR_DATA_W-1:0] v;
      logic                            m;
      int                              r;
      int                              mpix;
      int                              n;
      int                              pause_at;
      bit                              first_round;
      int                              k;

      reset               = 1'b1;
      csr_we              = 1'b0;
      csr_index           = lpse_pkg::CSR_MODE;
      csr_wdata           = '0;
      req_ch.valid        = 1'b0;
      req_ch.first_pixel  = 1'b0;
      req_ch.blue_in      = '0;
      req_ch.message_byte = '0;
      rsp_ch.ready        = 1'b0;
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, mode change inside a header, restart, zero length.
      write_reg(lpse_pkg::CSR_MODE, {31'b0, lpse_pkg::MODE_EMBED});
      write_reg(lpse_pkg::CSR_MESSAGE_LENGTH, 32'hFFFF_FFFF);
      send_pixel(1'b1, 8'h00, 8'h00);
      send_pixel(1'b0, 8'hFF, 8'hFF);
      send_pixel(1'b0, 8'h00, 8'hFF);
      send_pixel(1'b0, 8'hFF, 8'h00);
      repeat (4) send_pixel(1'b0, 8'($urandom), 8'($urandom));
      wait_drained();
      write_reg(lpse_pkg::CSR_MODE, {31'b0, lpse_pkg::MODE_EXTRACT});
      send_pixel(1'b0, 8'hFF, 8'h00);
      send_pixel(1'b0, 8'h00, 8'hFF);
      send_pixel(1'b0, 8'hFF, 8'hFF);
      send_pixel(1'b1, 8'h01, 8'h00);
      send_pixel(1'b0, 8'hFE, 8'h00);
      repeat (3) send_pixel(1'b0, 8'($urandom), 8'($urandom));
      wait_drained();
      write_reg(lpse_pkg::CSR_MODE, {31'b0, lpse_pkg::MODE_EMBED});
      write_reg(lpse_pkg::CSR_MESSAGE_LENGTH, 32'h0000_0000);
      send_pixel(1'b1, 8'hFF, 8'hFF);
      repeat (3) send_pixel(1'b0, 8'($urandom), 8'($urandom));

      first_round = 1'b1;
      while (pixels_sent < 1700) begin
         wait_drained();
         m = 1'($urandom_range(1, 0));
         v = $urandom;
         v[0] = m;
         write_reg(lpse_pkg::CSR_MODE, v);
         r = $urandom_range(19, 0);
         if (m == lpse_pkg::MODE_EMBED) begin
            if (r < 14)      len = $urandom_range(6, 0);
            else if (r < 16) len = '0;
            else if (r < 18) len = 32'hFFFF_FFFF;
            else             len = $urandom;
            write_reg(lpse_pkg::CSR_MESSAGE_LENGTH, len);
            hdr  = '0;
            mpix = (len <= 6) ? int'(len) * 8 : $urandom_range(64, 8);
         end else begin
            if (r < 14)       hdr = 64'($urandom_range(6, 0));
            else if (r < 16)  hdr = {$urandom, $urandom};
            else if (r == 16) hdr = 64'h0000_0000_FFFF_FFFF;
            else if (r == 17) hdr = 64'h0000_0001_0000_0000;
            else              hdr = '0;
            mpix = (hdr <= 6) ? int'(hdr) * 8 : $urandom_range(64, 8);
         end
         // Cut a message short now and then; a later image with first_pixel set restarts it.
         if ($urandom_range(9, 0) == 0 && mpix > 0)
            mpix = $urandom_range(mpix - 1, 0);
         n = lpse_pkg::HEADER_BITS + mpix + $urandom_range(12, 0);
         pause_at = (first_round || $urandom_range(9, 0) == 0) ? $urandom_range(n - 1, 1) : -1;
         run_image(n, hdr, m == lpse_pkg::MODE_EXTRACT, $urandom_range(9, 0) != 0, pause_at,
                   pause_at >= 0 && $urandom_range(1, 0) == 1);
         first_round = 1'b0;
      end

      req_ch.valid <= 1'b0;
      k = 0;
      while (shadow.pending_beats.size() != 0 && k < 10000) begin
         @(posedge clock);
         k++;
      end
      repeat (4) @(posedge clock);
      if (shadow.mismatches == 0 && shadow.pending_beats.size() == 0) begin
         $display("lsb_pixel_stego_embed_extract_core test passed");
      end else begin
         if (shadow.pending_beats.size() != 0)
            $display("%0t: %0d expected beats never arrived, next %0h", $time,
                     shadow.pending_beats.size(), shadow.pending_beats[0]);
         $display("lsb_pixel_stego_embed_extract_core test failed");
      end
      $finish;
   end

endmodule

@@ filelist.f @@
+incdir+sv
sv/lpse_pkg.sv
sv/lpse_req_if.sv
sv/lpse_rsp_if.sv
sv/lpse_step.sv
sv/lsb_pixel_stego_embed_extract_core.sv
sim/lsb_pixel_stego_embed_extract_core_tb.sv
